### rtl/assert_macros.svh
// assertion helpers, sampled on clk and disabled during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

### rtl/mfb_pkg.sv
`default_nettype none
package mfb_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int CAP_WIDTH_DEF    = 16;
  localparam int QUEUE_DEPTH_DEF  = 16;

  localparam int FLOW_W = 20;
  localparam logic [FLOW_W-1:0] FLOW_MAX = 20'hFFFFF;

  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_SOURCE = 2'd0;
  localparam logic [1:0] REG_SINK   = 2'd1;
  localparam logic [1:0] REG_COUNT  = 2'd2;

  localparam logic [3:0] SOURCE_RST = 4'd0;
  localparam logic [3:0] SINK_RST   = 4'd1;
  localparam logic [4:0] COUNT_RST  = 5'd6;

  typedef struct packed {
    logic [3:0] source_vertex;
    logic [3:0] sink_vertex;
    logic [4:0] vertex_count;
  } cfg_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_INIT,
    S_POP,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_MIN_RD,
    S_MIN_CHK,
    S_AUG_RD,
    S_AUG_FWD,
    S_AUG_REV,
    S_FINISH
  } state_t;

endpackage
`default_nettype wire

### rtl/max_flow_bfs_augmenting.sv
`default_nettype none
// Edges stream in one transaction per cycle while idle (in_ready is low in
// every other state) and are written into a residual capacity matrix held in
// a RAM with one read and one write port; a repeated edge overwrites and a
// self loop is dropped. The edge marked last_edge starts Edmonds-Karp: a
// sequencer drives one RAM read and one compare per step, the search scans
// the row of each dequeued vertex, each augmenting path is walked hop by hop,
// and one result comes out per last edge. Afterwards, and after reset, a
// clearing pass over all MAX_VERTICES**2 entries (256 by default; rounded up
// to a power of two) wipes the matrix, and no edge is taken meanwhile.
// Register writes are taken at any time, but should only happen when idle.
module max_flow_bfs_augmenting #(
  parameter int MAX_VERTICES = mfb_pkg::MAX_VERTICES_DEF,
  parameter int CAP_WIDTH    = mfb_pkg::CAP_WIDTH_DEF,
  parameter int QUEUE_DEPTH  = mfb_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mfb_pkg::ADDR_W-1:0]    paddr,
  input  wire logic [31:0]                   pwdata,
  output logic      [31:0]                   prdata,
  output logic                               pready,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [3:0]                    from_vertex,
  input  wire logic [3:0]                    to_vertex,
  input  wire logic [15:0]                   edge_capacity,
  input  wire logic                          last_edge,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [mfb_pkg::FLOW_W-1:0]    max_flow
);
  import mfb_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES);
  localparam int AW  = 2 * VW;
  localparam int RW  = CAP_WIDTH + 1;
  localparam int QW  = $clog2(QUEUE_DEPTH + 1);
  localparam int QIW = $clog2(QUEUE_DEPTH);
  localparam int SW  = ((RW > FLOW_W) ? RW : FLOW_W) + 1;

  cfg_t cfg;

  state_t state, state_next;

  logic [AW-1:0]     clr_addr;
  logic [QW-1:0]     head, tail;
  logic [VW-1:0]     queue [QUEUE_DEPTH];
  logic [VW-1:0]     pred [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] visited;
  logic [VW-1:0]     u_cur;
  logic [VW:0]       v_cnt;
  logic [VW-1:0]     walk_v;
  logic [RW-1:0]     amount;
  logic [FLOW_W-1:0] total;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [RW-1:0] wdata, rdata;

  logic [7:0]    n_lim;
  logic          trivial;
  logic [VW-1:0] src, dst, walk_u, v_idx;
  logic [47:0]   cap_wide;
  logic [RW-1:0] cap_ext;
  logic          edge_ok, in_fire, out_free, found;
  logic [SW-1:0] sum;

  mfb_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mfb_ram #(.AW(AW), .DW(RW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign n_lim    = (8'(cfg.vertex_count) > 8'(MAX_VERTICES)) ? 8'(MAX_VERTICES)
                                                               : 8'(cfg.vertex_count);
  assign trivial  = (cfg.source_vertex == cfg.sink_vertex) ||
                    (8'(cfg.source_vertex) >= n_lim) || (8'(cfg.sink_vertex) >= n_lim);
  assign src      = VW'(cfg.source_vertex);
  assign dst      = VW'(cfg.sink_vertex);
  assign walk_u   = pred[walk_v];
  assign v_idx    = v_cnt[VW-1:0];
  assign cap_wide = 48'(edge_capacity);
  assign cap_ext  = RW'(cap_wide[CAP_WIDTH-1:0]);
  assign edge_ok  = (from_vertex != to_vertex) && (8'(from_vertex) < 8'(MAX_VERTICES)) &&
                    (8'(to_vertex) < 8'(MAX_VERTICES));
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign found    = !visited[v_idx] && (rdata != '0) && (tail < QW'(QUEUE_DEPTH));
  assign sum      = SW'(total) + SW'(amount);

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:    if (&clr_addr) state_next = S_IDLE;
      S_IDLE:     if (in_fire && last_edge) state_next = S_START;
      S_START:    state_next = trivial ? S_FINISH : S_INIT;
      S_INIT:     state_next = S_POP;
      S_POP: begin
        if (head < tail) state_next = S_SCAN_RD;
        else if (visited[dst]) state_next = S_MIN_RD;
        else state_next = S_FINISH;
      end
      S_SCAN_RD:  state_next = (8'(v_cnt) < n_lim) ? S_SCAN_CHK : S_POP;
      S_SCAN_CHK: state_next = S_SCAN_RD;
      S_MIN_RD:   state_next = S_MIN_CHK;
      S_MIN_CHK:  state_next = (walk_u == src) ? S_AUG_RD : S_MIN_RD;
      S_AUG_RD:   state_next = S_AUG_FWD;
      S_AUG_FWD:  state_next = S_AUG_REV;
      S_AUG_REV:  state_next = (walk_u == src) ? S_INIT : S_AUG_RD;
      S_FINISH:   if (out_free) state_next = S_CLEAR;
      default:    state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = clr_addr;
    wdata = '0;
    raddr = {walk_u, walk_v};
    case (state)
      S_CLEAR: we = 1'b1;
      S_IDLE: begin
        we    = in_fire && edge_ok;
        waddr = {VW'(from_vertex), VW'(to_vertex)};
        wdata = cap_ext;
      end
      S_SCAN_RD: raddr = {u_cur, v_idx};
      S_AUG_FWD: begin
        we    = 1'b1;
        waddr = {walk_u, walk_v};
        wdata = rdata - amount;
        raddr = {walk_v, walk_u};
      end
      S_AUG_REV: begin
        we    = 1'b1;
        waddr = {walk_v, walk_u};
        wdata = rdata + amount;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      head      <= '0;
      tail      <= '0;
      visited   <= '0;
      total     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FINISH && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      case (state)
        S_CLEAR: clr_addr <= clr_addr + AW'(1);
        S_START: total <= '0;
        S_INIT: begin
          visited      <= MAX_VERTICES'(1) << src;
          queue[0]     <= src;
          head         <= '0;
          tail         <= QW'(1);
        end
        S_POP: begin
          if (head < tail) begin
            u_cur <= queue[head[QIW-1:0]];
            head  <= head + QW'(1);
            v_cnt <= '0;
          end else begin
            walk_v <= dst;
            amount <= '1;
          end
        end
        S_SCAN_CHK: begin
          if (found) begin
            visited[v_idx]          <= 1'b1;
            pred[v_idx]             <= u_cur;
            queue[tail[QIW-1:0]]    <= v_idx;
            tail                    <= tail + QW'(1);
          end
          v_cnt <= v_cnt + (VW+1)'(1);
        end
        S_MIN_CHK: begin
          if (rdata < amount) amount <= rdata;
          walk_v <= (walk_u == src) ? dst : walk_u;
        end
        S_AUG_REV: begin
          walk_v <= walk_u;
          if (walk_u == src) total <= (sum > SW'(FLOW_MAX)) ? FLOW_MAX : sum[FLOW_W-1:0];
        end
        S_FINISH: begin
          if (out_free) begin
            max_flow  <= total;
            clr_addr  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

`include "assert_macros.svh"

  `CHK_IMPL(a_queue_order, 1'b1, (head <= tail) && (tail <= QW'(QUEUE_DEPTH)))
  `CHK_NEXT(a_last_starts, in_valid && in_ready && last_edge, state == S_START)
  `CHK_IMPL(a_result_src, $rose(out_valid), $past(state) == S_FINISH)
  `CHK_IMPL(a_amount_pos, state == S_AUG_RD, amount != '0)

endmodule
`default_nettype wire

### rtl/mfb_ram.sv
`default_nettype none
module mfb_ram #(
  parameter int AW = 8,
  parameter int DW = 17
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/mfb_cfg.sv
`default_nettype none
module mfb_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mfb_pkg::ADDR_W-1:0]  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output mfb_pkg::cfg_t                    cfg
);
  import mfb_pkg::*;

  logic [1:0] idx;

  assign idx    = paddr[3:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_vertex <= SOURCE_RST;
      cfg.sink_vertex   <= SINK_RST;
      cfg.vertex_count  <= COUNT_RST;
    end else if (psel && penable && pwrite) begin
      case (idx)
        REG_SOURCE: cfg.source_vertex <= pwdata[3:0];
        REG_SINK:   cfg.sink_vertex   <= pwdata[3:0];
        REG_COUNT:  cfg.vertex_count  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SOURCE: prdata = 32'(cfg.source_vertex);
      REG_SINK:   prdata = 32'(cfg.sink_vertex);
      REG_COUNT:  prdata = 32'(cfg.vertex_count);
      default:    prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire
